[hw/rtl/ipl4pf_pkg.sv]
package ipl4pf_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_PORT   = 8'd1;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 336;

  // Frame byte offsets of interest, counted from the Ethernet destination.
  localparam logic [6:0] OFF_ETYPE_HI   = 7'd12;
  localparam logic [6:0] OFF_ETYPE_LO   = 7'd13;
  localparam logic [6:0] OFF_VER_IHL    = 7'd14;
  localparam logic [6:0] OFF_TOS        = 7'd15;
  localparam logic [6:0] OFF_TLEN_HI    = 7'd16;
  localparam logic [6:0] OFF_TLEN_LO    = 7'd17;
  localparam logic [6:0] OFF_ID_HI      = 7'd18;
  localparam logic [6:0] OFF_ID_LO      = 7'd19;
  localparam logic [6:0] OFF_FRAG_HI    = 7'd20;
  localparam logic [6:0] OFF_FRAG_LO    = 7'd21;
  localparam logic [6:0] OFF_TTL        = 7'd22;
  localparam logic [6:0] OFF_PROTO      = 7'd23;
  localparam logic [6:0] OFF_ADDR_FIRST = 7'd26;
  localparam logic [6:0] OFF_ADDR_LAST  = 7'd33;
  localparam logic [6:0] ETH_HDR_BYTES  = 7'd14;
  localparam logic [6:0] OFFSET_MAX     = 7'd127;

  // Offsets inside the L4 header.
  localparam logic [6:0] REL_PORTS_END  = 7'd4;
  localparam logic [6:0] REL_SEQACK_END = 7'd12;
  localparam logic [6:0] REL_DOFF       = 7'd12;
  localparam logic [6:0] REL_FLAGS      = 7'd13;
  localparam logic [6:0] REL_WIN_HI     = 7'd14;
  localparam logic [6:0] REL_WIN_LO     = 7'd15;
  localparam logic [6:0] TCP_LAST_REL   = 7'd19;
  localparam logic [6:0] UDP_LAST_REL   = 7'd7;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Filter settings as seen by the parser.
  typedef struct packed {
    logic        filter_enable;
    logic [15:0] target_port;
  } cfg_t;

  // One metadata record.
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
    logic [15:0] total_length;
    logic [7:0]  protocol;
    logic [15:0] ttl_tos;
    logic [5:0]  ip_header_bytes;
    logic [31:0] ip_id_frag;
    logic [31:0] port_pair;
    logic [63:0] tcp_seq_ack;
    logic [29:0] tcp_misc;
    logic        record_direction;
    logic [63:0] timestamp;
  } rec_t;

endpackage

[hw/rtl/ipv4_l4_header_port_filter.sv]
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  tdata: data_byte, time_ns; tlast: frame_last;
//                                          tuser: direction
// out_     master     out_tvalid/out_tready tdata: record fields; tuser: record_direction
// cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is accepted per cycle while the skid entry is free; the frame parser
// updates its header state in the cycle the byte is taken, and a matching record
// is written to the output register, or to the skid entry while out_ is stalled.
// rst_n is synchronous: the byte counter, drop flag, buffer and filter settings clear.
// A stalled out_ side is absorbed by a one-record skid entry; in_tready drops only
// while that entry is occupied. cfg_ready is always high.
module ipv4_l4_header_port_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [7:0] data_byte, [71:8] time_ns
  input  logic [ipl4pf_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                  in_tlast,
  // [0] direction
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [31:0] src_ip, [63:32] dest_ip, [79:64] total_length, [87:80] protocol,
  // [103:88] ttl_tos, [109:104] ip_header_bytes, [141:110] ip_id_frag,
  // [173:142] port_pair, [237:174] tcp_seq_ack, [267:238] tcp_misc,
  // [331:268] timestamp, [335:332] zero
  output logic [ipl4pf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] record_direction
  output logic                                  out_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ipl4pf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ipl4pf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ipl4pf_pkg::*;

  logic        in_fire;
  logic        rec_valid;
  rec_t        rec;
  rec_t        out_rec;
  cfg_t        cfg_r, cfg_nxt;
  logic        can_accept;

  assign in_tready = can_accept;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Filter register writes; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FILTER_ENABLE: cfg_nxt.filter_enable = cfg_data[0];
        REG_TARGET_PORT:   cfg_nxt.target_port   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ipl4pf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .data_byte  (in_tdata[7:0]),
    .frame_last (in_tlast),
    .direction  (in_tuser),
    .time_ns    (in_tdata[71:8]),
    .cfg        (cfg_r),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  ipl4pf_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire && rec_valid),
    .push_rec   (rec),
    .can_accept (can_accept),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_rec    (out_rec)
  );

  // Pack the record, first field in the lowest bits.
  assign out_tdata = {4'b0000, out_rec.timestamp, out_rec.tcp_misc, out_rec.tcp_seq_ack,
                      out_rec.port_pair, out_rec.ip_id_frag, out_rec.ip_header_bytes,
                      out_rec.ttl_tos, out_rec.protocol, out_rec.total_length,
                      out_rec.dest_ip, out_rec.src_ip};
  assign out_tuser = out_rec.record_direction;

endmodule

[hw/rtl/ipl4pf_parser.sv]
module ipl4pf_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         data_byte,
  input  logic               frame_last,
  input  logic               direction,
  input  logic [63:0]        time_ns,
  input  ipl4pf_pkg::cfg_t   cfg,
  output logic               rec_valid,
  output ipl4pf_pkg::rec_t   rec
);
  import ipl4pf_pkg::*;

  logic [6:0]  byte_offset_r, byte_offset_nxt;
  logic        frame_dropped_r, frame_dropped_nxt;
  logic        frame_dir_r, frame_dir_nxt;
  logic [7:0]  etype_hi_r, etype_hi_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [63:0] ip_addr_r, ip_addr_nxt;
  logic [63:0] ip_misc_r, ip_misc_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] l4_ports_r, l4_ports_nxt;
  logic [63:0] l4_seq_ack_r, l4_seq_ack_nxt;
  logic [29:0] l4_misc_r, l4_misc_nxt;

  logic [6:0]  l4_start;
  logic [6:0]  rel;
  logic        is_tcp;
  logic        l4_active;
  logic        l4_done;
  logic        port_match;

  // Where the L4 header starts and how far into it the current byte lies.
  assign l4_start   = ETH_HDR_BYTES + {1'b0, ihl_r, 2'b00};
  assign rel        = byte_offset_r - l4_start;
  assign is_tcp     = (proto_r == PROTO_TCP);
  assign l4_active  = !frame_dropped_r && (ihl_r >= IHL_MIN) &&
                      (byte_offset_r >= l4_start) && (byte_offset_r > OFF_ADDR_LAST);
  assign l4_done    = l4_active && (rel == (is_tcp ? TCP_LAST_REL : UDP_LAST_REL));
  assign port_match = (l4_ports_r[31:16] == cfg.target_port) ||
                      (l4_ports_r[15:0] == cfg.target_port);

  // Every captured field is written once per frame before it can be reported,
  // so the capture registers are overwritten in place rather than cleared.
  always_comb begin
    byte_offset_nxt   = byte_offset_r;
    frame_dropped_nxt = frame_dropped_r;
    frame_dir_nxt     = frame_dir_r;
    etype_hi_nxt      = etype_hi_r;
    ihl_nxt           = ihl_r;
    ip_addr_nxt       = ip_addr_r;
    ip_misc_nxt       = ip_misc_r;
    proto_nxt         = proto_r;
    l4_ports_nxt      = l4_ports_r;
    l4_seq_ack_nxt    = l4_seq_ack_r;
    l4_misc_nxt       = l4_misc_r;

    if (byte_offset_r == 7'd0) begin
      frame_dir_nxt = direction;
    end

    if (!frame_dropped_r) begin
      case (byte_offset_r) inside
        OFF_ETYPE_HI: etype_hi_nxt = data_byte;
        OFF_ETYPE_LO: begin
          if ({etype_hi_r, data_byte} != ETHERTYPE_IPV4) begin
            frame_dropped_nxt = 1'b1;
          end
        end
        OFF_VER_IHL: begin
          ihl_nxt = data_byte[3:0];
          if (data_byte[3:0] < IHL_MIN) begin
            frame_dropped_nxt = 1'b1;
          end
        end
        OFF_TOS:     ip_misc_nxt[39:32] = data_byte;
        OFF_TLEN_HI: ip_misc_nxt[63:56] = data_byte;
        OFF_TLEN_LO: ip_misc_nxt[55:48] = data_byte;
        OFF_ID_HI:   ip_misc_nxt[31:24] = data_byte;
        OFF_ID_LO:   ip_misc_nxt[23:16] = data_byte;
        OFF_FRAG_HI: ip_misc_nxt[15:8]  = data_byte;
        OFF_FRAG_LO: ip_misc_nxt[7:0]   = data_byte;
        OFF_TTL:     ip_misc_nxt[47:40] = data_byte;
        OFF_PROTO: begin
          proto_nxt = data_byte;
          if ((data_byte != PROTO_TCP) && (data_byte != PROTO_UDP)) begin
            frame_dropped_nxt = 1'b1;
          end
        end
        [OFF_ADDR_FIRST:OFF_ADDR_LAST]: ip_addr_nxt = {ip_addr_r[55:0], data_byte};
        default: begin
          if (l4_active) begin
            if (rel < REL_PORTS_END) begin
              l4_ports_nxt = {l4_ports_r[23:0], data_byte};
            end else if (is_tcp) begin
              if (rel < REL_SEQACK_END) begin
                l4_seq_ack_nxt = {l4_seq_ack_r[55:0], data_byte};
              end else if (rel == REL_DOFF) begin
                l4_misc_nxt[23:16] = {2'b00, data_byte[7:4], 2'b00};
              end else if (rel == REL_FLAGS) begin
                l4_misc_nxt[29:24] = data_byte[5:0];
              end else if (rel == REL_WIN_HI) begin
                l4_misc_nxt[15:8] = data_byte;
              end else if (rel == REL_WIN_LO) begin
                l4_misc_nxt[7:0] = data_byte;
              end
            end
            // One record point per frame.
            if (l4_done) begin
              frame_dropped_nxt = 1'b1;
            end
          end
        end
      endcase
    end

    // Byte counter saturates; the final byte restarts the frame.
    if (byte_offset_r != OFFSET_MAX) begin
      byte_offset_nxt = byte_offset_r + 7'd1;
    end
    if (frame_last) begin
      byte_offset_nxt   = 7'd0;
      frame_dropped_nxt = 1'b0;
    end
  end

  // Record fields come from the captured header and the current byte's time.
  always_comb begin
    rec_valid            = l4_done && cfg.filter_enable && port_match;
    rec.src_ip           = ip_addr_r[63:32];
    rec.dest_ip          = ip_addr_r[31:0];
    rec.total_length     = ip_misc_r[63:48];
    rec.protocol         = proto_r;
    rec.ttl_tos          = ip_misc_r[47:32];
    rec.ip_header_bytes  = {ihl_r, 2'b00};
    rec.ip_id_frag       = ip_misc_r[31:0];
    rec.port_pair        = l4_ports_r;
    rec.tcp_seq_ack      = is_tcp ? l4_seq_ack_r : 64'd0;
    rec.tcp_misc         = is_tcp ? l4_misc_r : 30'd0;
    rec.record_direction = frame_dir_r;
    rec.timestamp        = time_ns;
  end

  // Frame tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r   <= 7'd0;
      frame_dropped_r <= 1'b0;
    end else if (in_fire) begin
      byte_offset_r   <= byte_offset_nxt;
      frame_dropped_r <= frame_dropped_nxt;
    end
  end

  // Header capture registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      frame_dir_r  <= frame_dir_nxt;
      etype_hi_r   <= etype_hi_nxt;
      ihl_r        <= ihl_nxt;
      ip_addr_r    <= ip_addr_nxt;
      ip_misc_r    <= ip_misc_nxt;
      proto_r      <= proto_nxt;
      l4_ports_r   <= l4_ports_nxt;
      l4_seq_ack_r <= l4_seq_ack_nxt;
      l4_misc_r    <= l4_misc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A reported frame reports nothing more until it ends.
  a_single_record: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && rec_valid) |=> (frame_dropped_r || (byte_offset_r == 7'd0)))
    else $error("record point reached without closing the frame");

  // The record point lies past the shortest IPv4 header.
  a_record_offset: assert property (@(posedge clk) disable iff (!rst_n)
    rec_valid |-> (byte_offset_r > OFF_ADDR_LAST))
    else $error("record raised inside the IPv4 header");

  // A record is only raised for TCP or UDP.
  a_record_proto: assert property (@(posedge clk) disable iff (!rst_n)
    rec_valid |-> ((proto_r == PROTO_TCP) || (proto_r == PROTO_UDP)))
    else $error("record raised for an unsupported protocol");
`endif

endmodule

[hw/rtl/ipl4pf_out_buf.sv]
module ipl4pf_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ipl4pf_pkg::rec_t  push_rec,
  output logic              can_accept,
  output logic              out_valid,
  input  logic              out_ready,
  output ipl4pf_pkg::rec_t  out_rec
);
  import ipl4pf_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  rec_t main_r, main_nxt;
  rec_t skid_r, skid_nxt;
  logic pop;
  logic [1:0] occ;

  assign pop        = out_valid_r && out_ready;
  assign can_accept = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_rec    = main_r;
  assign occ        = {1'b0, out_valid_r} + {1'b0, skid_valid_r};

  // Two-entry buffer: the output register plus a skid entry that catches one
  // record while the output is stalled.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        main_nxt      = push_rec;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_rec;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

`ifndef NO_ASSERTIONS
  // The skid entry is only used behind a full output register.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a record while the output is empty");

  // No record arrives while the buffer is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && skid_valid_r))
    else $error("record pushed into a full buffer");

  // Occupancy follows pushes and pops exactly.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (occ == ($past(occ) + {1'b0, $past(push)} - {1'b0, $past(pop)})))
    else $error("record lost or duplicated in the output buffer");
`endif

endmodule
